// ----- sv/fsrq_pkg.sv -----
// Shared types, codes and the nice-to-weight table for the fair-share run queue.
`default_nettype none
package fsrq_pkg;

    localparam int SLICE_W  = 15;
    localparam int WEIGHT_W = 11;
    localparam int VR_W     = 31;
    localparam int ID_W     = 6;
    localparam int ORDER_W  = 32;
    localparam int GRAN_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXTRACT = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LATENCY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GRAN       = 1'd1;

    localparam logic [SLICE_W-1:0] TL_RESET = 15'd32;
    localparam logic [GRAN_W-1:0]  MG_RESET = 8'd2;
    localparam logic [SLICE_W-1:0] PERIOD_MAX = 15'h7FFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ID_W-1:0]    task_id;
        logic [VR_W-1:0]    virtual_runtime;
        logic [4:0]         nice_level;
        logic [30:0]        run_ticks;
        logic [SLICE_W-1:0] slice_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     chosen_id;
        logic [SLICE_W-1:0]  granted_slice;
        logic [WEIGHT_W-1:0] chosen_weight;
        logic                preempt;
    } t_out;

    typedef struct packed {
        logic [VR_W-1:0]     vr;
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
        logic [ORDER_W-1:0]  order;
    } t_entry;

    typedef struct packed {
        logic start;
        logic idx_inc;
        logic ins_write;
        logic ext_commit;
        logic period_set;
        logic div_start;
        logic ext_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic slot_free;
        logic scan_done;
        logic found;
        logic div_done;
    } t_stat;

    // floor(1024 * 0.8^n); nice above 27 all map to 1
    function automatic logic [WEIGHT_W-1:0] nice_weight(input logic [4:0] nice);
        logic [WEIGHT_W-1:0] w;
        case (nice)
            5'd0:  w = 11'd1024;
            5'd1:  w = 11'd819;
            5'd2:  w = 11'd655;
            5'd3:  w = 11'd524;
            5'd4:  w = 11'd419;
            5'd5:  w = 11'd335;
            5'd6:  w = 11'd268;
            5'd7:  w = 11'd214;
            5'd8:  w = 11'd171;
            5'd9:  w = 11'd137;
            5'd10: w = 11'd109;
            5'd11: w = 11'd87;
            5'd12: w = 11'd70;
            5'd13: w = 11'd56;
            5'd14: w = 11'd45;
            5'd15: w = 11'd36;
            5'd16: w = 11'd28;
            5'd17: w = 11'd23;
            5'd18: w = 11'd18;
            5'd19: w = 11'd14;
            5'd20: w = 11'd11;
            5'd21: w = 11'd9;
            5'd22: w = 11'd7;
            5'd23: w = 11'd6;
            5'd24: w = 11'd4;
            5'd25: w = 11'd3;
            5'd26: w = 11'd3;
            5'd27: w = 11'd2;
            default: w = 11'd1;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/fsrq_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fsrq_div #(
    parameter int DW = 26,
    parameter int SW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [SW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [SW-1:0]    r_rem;
    logic [DW-1:0]    r_q;
    logic [SW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [SW:0]      shifted;
    logic             ge;

    assign shifted = {r_rem, r_q[DW-1]};
    assign ge      = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DW);
            r_rem  <= '0;
            r_q    <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? SW'(shifted - {1'b0, r_div}) : shifted[SW-1:0];
            r_q   <= {r_q[DW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ----- sv/fsrq_dp.sv -----
// Datapath: entry memory, valid bits, running totals, min scan, period and slice math.
`default_nettype none
module fsrq_dp
    import fsrq_pkg::*;
#(
    parameter int QUEUE_ENTRIES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in                   i_in_data,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output t_out                       o_out_data
);
    localparam int IW  = $clog2(QUEUE_ENTRIES);
    localparam int CW  = $clog2(QUEUE_ENTRIES + 1);
    localparam int SW  = $clog2(QUEUE_ENTRIES * 1024 + 1);
    localparam int PW0 = CW + GRAN_W;
    localparam int PW  = (PW0 > 16) ? PW0 : 16;
    localparam int DW  = SLICE_W + WEIGHT_W;

    t_entry mem [QUEUE_ENTRIES];

    logic [SLICE_W-1:0]       r_tl;
    logic [GRAN_W-1:0]        r_mg;
    t_in                      r_in;
    logic                     r_drop;
    logic [QUEUE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]            r_cnt;
    logic [SW-1:0]            r_sum;
    logic [ORDER_W-1:0]       r_seq;
    logic [SLICE_W-1:0]       r_period;
    logic [PW-1:0]            r_prod;
    logic [IW-1:0]            r_idx;
    logic                     r_busy;
    logic                     r_pend;
    logic                     r_rv;
    t_entry                   r_rdat;
    logic [IW-1:0]            r_ridx;
    logic                     r_found;
    t_entry                   r_best;
    logic [IW-1:0]            r_best_idx;
    logic [ORDER_W-1:0]       r_best_age;
    logic [SLICE_W-1:0]       r_slice;
    t_out                     r_out;
    t_out                     n_out;

    logic [ORDER_W-1:0] age_c;
    logic               take;
    logic [DW-1:0]      quot;
    logic               div_done;
    logic [DW-1:0]      dividend;
    logic [30:0]        mg_ext;
    logic               gran_ok;

    assign age_c = r_seq - r_rdat.order;
    assign take  = r_rv && (!r_found || (r_rdat.vr < r_best.vr) ||
                   ((r_rdat.vr == r_best.vr) && (age_c > r_best_age)));
    assign dividend = DW'(r_period) * DW'(r_best.weight);

    fsrq_div #(.DW(DW), .SW(SW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            mem[r_idx] <= '{vr: r_in.virtual_runtime, id: r_in.task_id,
                            weight: nice_weight(r_in.nice_level), order: r_seq};
        end
        r_rdat <= mem[r_idx];
        r_ridx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl     <= TL_RESET;
            r_mg     <= MG_RESET;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_seq    <= '0;
            r_period <= TL_RESET;
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TARGET_LATENCY) begin
                    r_tl <= i_cfg_data;
                end else if (i_cfg_idx == CFG_MIN_GRAN) begin
                    r_mg <= i_cfg_data[GRAN_W-1:0];
                end
            end

            // scan pipeline: address, registered read, compare
            r_pend <= r_busy;
            r_rv   <= r_busy && r_valid[r_idx];
            if (r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == IW'(QUEUE_ENTRIES - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (take) begin
                r_found    <= 1'b1;
                r_best     <= r_rdat;
                r_best_idx <= r_ridx;
                r_best_age <= age_c;
            end

            if (i_cmd.start) begin
                r_in    <= i_in_data;
                r_drop  <= r_cnt >= CW'(QUEUE_ENTRIES);
                r_idx   <= '0;
                r_busy  <= (i_in_data.opcode == OP_EXTRACT) ||
                           (i_in_data.opcode == OP_CHECK);
                r_found <= 1'b0;
                r_slice <= '0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.ins_write) begin
                r_valid[r_idx] <= 1'b1;
                r_seq <= r_seq + 1'b1;
                r_cnt <= r_cnt + 1'b1;
                r_sum <= r_sum + SW'(nice_weight(r_in.nice_level));
            end
            if (i_cmd.ext_commit) begin
                r_valid[r_best_idx] <= 1'b0;
                r_cnt  <= r_cnt - 1'b1;
                r_prod <= PW'(CW'(r_cnt - 1'b1)) * PW'(r_mg);
            end
            // count > tl / mg  is the same as  count * mg > tl
            if (i_cmd.period_set) begin
                if ((r_mg != '0) && (r_prod > PW'(r_tl))) begin
                    r_period <= (r_prod > PW'(PERIOD_MAX)) ? PERIOD_MAX
                                                           : r_prod[SLICE_W-1:0];
                end else begin
                    r_period <= r_tl;
                end
            end
            if (i_cmd.ext_finish) begin
                r_slice <= (r_sum == '0) ? '0 : quot[SLICE_W-1:0];
                r_sum   <= (r_sum >= SW'(r_best.weight)) ? r_sum - SW'(r_best.weight) : '0;
            end
        end
    end

    assign mg_ext  = 31'(r_mg);
    assign gran_ok = r_in.run_ticks >= mg_ext;

    always_comb begin
        n_out = '0;
        case (r_in.opcode)
            OP_INSERT: begin
                n_out.status = r_drop ? ST_FULL : ST_OK;
            end
            OP_EXTRACT: begin
                if (r_found) begin
                    n_out.chosen_id     = r_best.id;
                    n_out.granted_slice = r_slice;
                    n_out.chosen_weight = r_best.weight;
                end else begin
                    n_out.status = ST_EMPTY;
                end
            end
            OP_CHECK: begin
                n_out.preempt = ((r_in.run_ticks >= 31'(r_in.slice_ticks)) && gran_ok) ||
                                (r_found && (r_in.virtual_runtime > r_best.vr) &&
                                 ((r_in.run_ticks == '0) || gran_ok));
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_stat.drop      = r_drop;
    assign o_stat.slot_free = !r_valid[r_idx];
    assign o_stat.scan_done = !r_busy && !r_pend;
    assign o_stat.found     = r_found;
    assign o_stat.div_done  = div_done;
    assign o_out_data       = r_out;
endmodule
`default_nettype wire

// ----- sv/fsrq_ctrl.sv -----
// Controller: sequences insert, min scan, period, divide and result beats.
`default_nettype none
module fsrq_ctrl
    import fsrq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_op,
    input  wire logic       i_out_ready,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    typedef enum logic [2:0] {
        S_IDLE, S_INS, S_SCAN, S_COMMIT, S_PERIOD, S_DSTART, S_DIV, S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_op;
    logic       r_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    case (i_op) inside
                        OP_INSERT:            n_state = S_INS;
                        OP_EXTRACT, OP_CHECK: n_state = S_SCAN;
                        default:              n_state = S_FIN;
                    endcase
                end
            end
            S_INS: begin
                if (i_stat.drop) begin
                    n_state = S_FIN;
                end else if (i_stat.slot_free) begin
                    o_cmd.ins_write = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = (r_op == OP_EXTRACT && i_stat.found) ? S_COMMIT : S_FIN;
                end
            end
            S_COMMIT: begin
                o_cmd.ext_commit = 1'b1;
                n_state = S_PERIOD;
            end
            S_PERIOD: begin
                o_cmd.period_set = 1'b1;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.ext_finish = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_INSERT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.start) begin
                r_op <= i_op;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ----- sv/fair_share_run_queue_core.sv -----
// Fair-share run queue ordered by virtual runtime.
// Input channel (i_in_valid / o_in_ready, i_in_data): one command beat, insert,
// extract or preemption check. Output channel (o_out_valid / i_out_ready,
// o_out_data): exactly one result beat per command, in command order.
// Config port: i_cfg_we writes target_latency (index 0) or min_gran
// (index 1); write only while the queue has no command in flight.
// One command at a time. Steps from accept to result:
//   insert: free-slot walk over valid bits
//   extract: full min scan through the entry memory read port, then the
//   restoring divider for the slice
//   check and empty extract: the full min scan; unused opcode: none
// The next command is taken once the previous result sits in the output
// register, even if the receiver stalls; a stalled result holds its beat and
// the following command then waits at its last step until the register frees.
// Reset (synchronous, active low) empties the queue, clears totals and the
// insert sequence, and loads the register defaults; no clearing pass needed.
`default_nettype none
module fair_share_run_queue_core
    import fsrq_pkg::*;
#(
    parameter int QUEUE_ENTRIES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    fsrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.opcode),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    fsrq_dp #(.QUEUE_ENTRIES(QUEUE_ENTRIES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire

// ----- sv/fsrq_chk.sv -----
// Port-level checker for the run queue core and its bind.
`default_nettype none
module fsrq_chk
    import fsrq_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);
    // one command at a time: ready drops right after a beat is taken
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a command is in flight");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
        (o_out_data.chosen_id == '0) && (o_out_data.granted_slice == '0) &&
        (o_out_data.chosen_weight == '0) && !o_out_data.preempt)
        else $error("error result carries payload");

    a_preempt_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.preempt |->
        (o_out_data.status == ST_OK) && (o_out_data.chosen_weight == '0))
        else $error("preempt flag on a non-check result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind fair_share_run_queue_core fsrq_chk u_fsrq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ----- test/fair_share_run_queue_core_test.sv -----
// Self-checking testbench for the fair-share run queue core.
`timescale 1ns / 100ps
module fair_share_run_queue_core_test;
    import fsrq_pkg::*;

    localparam int SLOTS      = 64;
    localparam int DRAIN_WAIT = SLOTS + 60;
    localparam int STALL_MAX  = 3000;

    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [WEIGHT_W-1:0] LOAD_OF_NICE [0:30] = '{
        11'd1024, 11'd819, 11'd655, 11'd524, 11'd419, 11'd335, 11'd268, 11'd214,
        11'd171, 11'd137, 11'd109, 11'd87, 11'd70, 11'd56, 11'd45, 11'd36,
        11'd28, 11'd23, 11'd18, 11'd14, 11'd11, 11'd9, 11'd7, 11'd6,
        11'd4, 11'd3, 11'd3, 11'd2, 11'd1, 11'd1, 11'd1
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  o_in_ready;
    t_in                   in_data;
    logic                  o_out_valid;
    logic                  out_ready;
    t_out                  o_out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    fair_share_run_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // shadow run queue
    logic [VR_W-1:0]     task_vr    [SLOTS];
    logic [ID_W-1:0]     task_ident [SLOTS];
    logic [WEIGHT_W-1:0] task_load  [SLOTS];
    logic [31:0]         task_seq   [SLOTS];
    logic                task_live  [SLOTS];
    int unsigned         live_count;
    int unsigned         load_total;
    int unsigned         period_now;
    logic [31:0]         seq_next;
    int unsigned         latency_reg;
    int unsigned         gran_reg;

    t_in  cmd_pending [$];
    t_out result_due  [$];

    int   mismatches;
    int   idle_cycles;
    logic in_took;
    logic out_took;
    int   in_gap;
    int   out_hold;
    logic in_burst;
    logic out_burst;

    // least vruntime, oldest insert on ties; -1 when empty
    function automatic int earliest_task();
        int best;
        logic [31:0] best_age;
        logic [31:0] age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (task_live[i]) begin
                age = seq_next - task_seq[i];
                if (best < 0 || task_vr[i] < task_vr[best] ||
                    (task_vr[i] == task_vr[best] && age > best_age)) begin
                    best = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    task automatic schedule_step(input t_in c, output t_out r);
        int best;
        int slot;
        int unsigned nice;
        int unsigned w;
        longint unsigned p;
        r = '0;
        case (c.opcode)
            OP_INSERT: begin
                slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!task_live[i]) slot = i;
                if (live_count >= SLOTS || slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    nice = (c.nice_level > 30) ? 30 : c.nice_level;
                    task_live[slot]  = 1'b1;
                    task_ident[slot] = c.task_id;
                    task_vr[slot]    = c.virtual_runtime;
                    task_load[slot]  = LOAD_OF_NICE[nice];
                    task_seq[slot]   = seq_next;
                    seq_next++;
                    live_count++;
                    load_total += LOAD_OF_NICE[nice];
                end
            end
            OP_EXTRACT: begin
                best = earliest_task();
                if (best < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    w = task_load[best];
                    task_live[best] = 1'b0;
                    live_count--;
                    if (gran_reg != 0 && live_count > latency_reg / gran_reg) begin
                        p = live_count * gran_reg;
                        period_now = 32'((p > 64'd32767) ? 64'd32767 : p);
                    end else begin
                        period_now = latency_reg;
                    end
                    p = (load_total != 0) ? (longint'(period_now) * w) / load_total : 0;
                    load_total = (load_total >= w) ? load_total - w : 0;
                    r.chosen_id     = task_ident[best];
                    r.granted_slice = p[SLICE_W-1:0];
                    r.chosen_weight = w[WEIGHT_W-1:0];
                end
            end
            OP_CHECK: begin
                best = earliest_task();
                if (c.run_ticks >= c.slice_ticks && c.run_ticks >= gran_reg)
                    r.preempt = 1'b1;
                else if (best >= 0 && c.virtual_runtime > task_vr[best] &&
                         (c.run_ticks == 0 || c.run_ticks >= gran_reg))
                    r.preempt = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic t_in make_cmd(input logic [1:0] op, input int id,
                                     input logic [VR_W-1:0] vr, input int nice,
                                     input logic [30:0] ticks,
                                     input logic [SLICE_W-1:0] slice);
        t_in c;
        c.opcode = op;
        c.task_id = ID_W'(id);
        c.virtual_runtime = vr;
        c.nice_level = 5'(nice);
        c.run_ticks = ticks;
        c.slice_ticks = slice;
        return c;
    endfunction

    function automatic t_in random_cmd(input int insert_pct);
        t_in c;
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)                           c.opcode = OP_INSERT;
        else if (r < insert_pct + (100 - insert_pct) * 2 / 3) c.opcode = OP_EXTRACT;
        else if (r < 98)                              c.opcode = OP_CHECK;
        else                                          c.opcode = OP_SPARE;
        c.task_id = ID_W'($urandom);
        c.nice_level = 5'($urandom);
        case ($urandom_range(0, 3))
            0:       c.virtual_runtime = VR_W'($urandom_range(0, 7));
            1:       c.virtual_runtime = VR_W'($urandom_range(0, 1000));
            default: c.virtual_runtime = VR_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       c.run_ticks = '0;
            1:       c.run_ticks = 31'($urandom_range(0, 300));
            2:       c.run_ticks = 31'($urandom);
            default: c.run_ticks = 31'($urandom_range(0, 20));
        endcase
        case ($urandom_range(0, 2))
            0:       c.slice_ticks = SLICE_W'($urandom_range(0, 300));
            1:       c.slice_ticks = SLICE_W'($urandom);
            default: c.slice_ticks = 15'd16384;
        endcase
        return c;
    endfunction

    function automatic int draw_wait(input logic burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_TARGET_LATENCY) latency_reg = value & 32'h7FFF;
        else                           gran_reg    = value & 32'hFF;
    endtask

    task automatic wait_quiet();
        while (cmd_pending.size() != 0 || result_due.size() != 0 || in_valid)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // command side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_took) in_gap = draw_wait(in_burst);
            if (in_valid && !in_took) begin
                // hold the beat
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (cmd_pending.size() != 0) begin
                in_data  <= cmd_pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_took) out_hold = draw_wait(out_burst);
            if (out_hold > 0) begin
                out_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        in_took  <= i_rst_n && in_valid && o_in_ready;
        out_took <= i_rst_n && o_out_valid && out_ready;
        if ($urandom_range(0, 199) == 0) in_burst  <= !in_burst;
        if ($urandom_range(0, 199) == 0) out_burst <= !out_burst;
        if (i_rst_n && in_valid && o_in_ready) begin
            schedule_step(in_data, want);
            result_due.push_back(want);
        end
        if (i_rst_n && o_out_valid && out_ready) begin
            if (result_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", o_out_data);
            end else begin
                want = result_due.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.chosen_id !== want.chosen_id ||
                    o_out_data.granted_slice !== want.granted_slice ||
                    o_out_data.chosen_weight !== want.chosen_weight ||
                    o_out_data.preempt !== want.preempt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, o_out_data);
                end
            end
        end
        if (i_rst_n && !(in_valid && o_in_ready) && !(o_out_valid && out_ready)
            && !cfg_we) begin
            idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("fair_share_run_queue_core_test NOT OK");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        int unsigned lat_set  [6] = '{32, 1, 16384, 32767, 100, 5};
        int unsigned gran_set [6] = '{2, 1, 255, 0, 3, 200};
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_took = 1'b0;
        out_took = 1'b0;
        in_gap = 0;
        out_hold = 0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        for (int i = 0; i < SLOTS; i++) task_live[i] = 1'b0;
        live_count = 0;
        load_total = 0;
        latency_reg = TL_RESET;
        gran_reg = MG_RESET;
        period_now = latency_reg;
        seq_next = '0;

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, ties, nice clamp, empty cases, unused opcode
        cmd_pending.push_back(make_cmd(OP_INSERT, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_INSERT, 63, '1, 30, '1, '1));
        cmd_pending.push_back(make_cmd(OP_INSERT, 5, 0, 31, 0, 0));
        cmd_pending.push_back(make_cmd(OP_INSERT, 10, 100, 15, 0, 0));
        cmd_pending.push_back(make_cmd(OP_CHECK, 0, '1, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_CHECK, 63, 0, 31, '1, 15'd16384));
        cmd_pending.push_back(make_cmd(OP_CHECK, 0, '1, 0, 1, 0));
        cmd_pending.push_back(make_cmd(OP_CHECK, 0, 50, 0, 2, '1));
        for (int i = 0; i < 5; i++)
            cmd_pending.push_back(make_cmd(OP_EXTRACT, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_CHECK, 0, '1, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_SPARE, 63, '1, 31, '1, '1));
        cmd_pending.push_back(make_cmd(OP_INSERT, 1, 7, 3, 0, 0));
        cmd_pending.push_back(make_cmd(OP_INSERT, 2, 7, 9, 0, 0));
        cmd_pending.push_back(make_cmd(OP_EXTRACT, 0, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_EXTRACT, 0, 0, 0, 0, 0));
        wait_quiet();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_TARGET_LATENCY, lat_set[ph]);
            write_reg(CFG_MIN_GRAN, gran_set[ph]);
            // alternate filling and draining stretches so the queue hits full
            for (int k = 0; k < 272; k++)
                cmd_pending.push_back(random_cmd(((k / 90) % 2 == 0) ? 75 : 30));
            wait_quiet();
        end

        if (mismatches == 0 && result_due.size() == 0) begin
            $display("fair_share_run_queue_core_test OK");
        end else begin
            $display("fair_share_run_queue_core_test NOT OK");
        end
        $finish;
    end

endmodule
